### rtl/core/wsid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wsid_pkg;

	// Source byte codes.
	localparam logic [7:0] NUL_CODE = 8'd0;
	localparam logic [7:0] TAB_CODE = 8'd9;
	localparam logic [7:0] LF_CODE  = 8'd10;
	localparam logic [7:0] SP_CODE  = 8'd32;

	// Symbol queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam int MAG_W = 63;

	typedef enum logic [1:0] {
		SYM_S,
		SYM_T,
		SYM_N,
		SYM_Z
	} sym_t;

	typedef struct packed {
		logic valid;
		sym_t sym;
	} sym_beat_t;

	typedef enum logic [4:0] {
		PH_GROUP,
		PH_GROUP_T,
		PH_STACK,
		PH_STACK_T,
		PH_STACK_N,
		PH_ARITH,
		PH_ARITH_S,
		PH_ARITH_T,
		PH_HEAP,
		PH_FLOW,
		PH_FLOW_S,
		PH_FLOW_T,
		PH_FLOW_N,
		PH_IO,
		PH_IO_S,
		PH_IO_T,
		PH_SIGN,
		PH_DIGITS,
		PH_LABEL
	} phase_t;

	localparam logic [1:0] KIND_INSTR    = 2'd0;
	localparam logic [1:0] KIND_ILLEGAL  = 2'd1;
	localparam logic [1:0] KIND_OVERFLOW = 2'd2;
	localparam logic [1:0] KIND_END      = 2'd3;

	localparam logic [2:0] GRP_STACK = 3'd0;
	localparam logic [2:0] GRP_ARITH = 3'd1;
	localparam logic [2:0] GRP_HEAP  = 3'd2;
	localparam logic [2:0] GRP_FLOW  = 3'd3;
	localparam logic [2:0] GRP_IO    = 3'd4;

	localparam logic [2:0] CMD_PUSH     = 3'd0;
	localparam logic [2:0] CMD_COPY     = 3'd1;
	localparam logic [2:0] CMD_SLIDE    = 3'd2;
	localparam logic [2:0] CMD_DUP      = 3'd3;
	localparam logic [2:0] CMD_SWAP     = 3'd4;
	localparam logic [2:0] CMD_DISCARD  = 3'd5;

	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_MOD = 3'd4;

	localparam logic [2:0] CMD_STORE    = 3'd0;
	localparam logic [2:0] CMD_RETRIEVE = 3'd1;

	localparam logic [2:0] CMD_MARK   = 3'd0;
	localparam logic [2:0] CMD_CALL   = 3'd1;
	localparam logic [2:0] CMD_JUMP   = 3'd2;
	localparam logic [2:0] CMD_JZ     = 3'd3;
	localparam logic [2:0] CMD_JNEG   = 3'd4;
	localparam logic [2:0] CMD_RET    = 3'd5;
	localparam logic [2:0] CMD_FINISH = 3'd6;

	localparam logic [2:0] CMD_PUTC = 3'd0;
	localparam logic [2:0] CMD_PUTN = 3'd1;
	localparam logic [2:0] CMD_GETC = 3'd2;
	localparam logic [2:0] CMD_GETN = 3'd3;

endpackage

`default_nettype wire

### rtl/core/wsid_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wsid_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                source_valid,
	output logic                     source_ready,
	input  wire logic [7:0]          source_byte,
	output wsid_pkg::sym_beat_t      head,
	input  wire logic                head_take
);

	wsid_pkg::sym_t                   queue_q [wsid_pkg::QUEUE_DEPTH];
	logic [wsid_pkg::QPTR_W-1:0]      wr_q;
	logic [wsid_pkg::QPTR_W-1:0]      rd_q;
	logic [wsid_pkg::QCNT_W-1:0]      count_q;
	logic                             is_sym;
	wsid_pkg::sym_t                   sym;
	logic                             push;
	logic                             pop;

	// Bytes that are not symbols are taken and dropped here.
	always_comb begin
		is_sym = 1'b1;
		sym    = wsid_pkg::SYM_S;
		unique case (source_byte)
			wsid_pkg::SP_CODE:  sym = wsid_pkg::SYM_S;
			wsid_pkg::TAB_CODE: sym = wsid_pkg::SYM_T;
			wsid_pkg::LF_CODE:  sym = wsid_pkg::SYM_N;
			wsid_pkg::NUL_CODE: sym = wsid_pkg::SYM_Z;
			default:            is_sym = 1'b0;
		endcase
	end

	assign source_ready = (count_q != wsid_pkg::QCNT_W'(wsid_pkg::QUEUE_DEPTH));
	assign push         = source_valid && source_ready && is_sym;
	assign pop          = head_take && head.valid;

	assign head.valid = (count_q != '0);
	assign head.sym   = queue_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_q] <= sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/wsid_back.sv
`timescale 1ns / 1ps
`default_nettype none

module wsid_back #(
	parameter int LABEL_BITS = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire wsid_pkg::sym_beat_t  head,
	output logic                      head_take,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output logic [1:0]                result_kind,
	output logic [2:0]                op_group,
	output logic [2:0]                op_command,
	output logic signed [63:0]        push_value,
	output logic [63:0]               label_bits,
	output logic [6:0]                label_length
);

	localparam int LCNT_W = $clog2(LABEL_BITS + 1);

	wsid_pkg::phase_t               phase_q, phase_n;
	logic [2:0]                     group_q, group_n;
	logic [2:0]                     cmd_q, cmd_n;
	logic                           neg_q, neg_n;
	logic [wsid_pkg::MAG_W-1:0]     mag_q, mag_n;
	logic [LABEL_BITS-1:0]          lbl_q, lbl_n;
	logic [LCNT_W-1:0]              lcnt_q, lcnt_n;
	logic                           stopped_q, stopped_n;

	logic                           res_valid_q;
	logic [1:0]                     res_kind_q;
	logic [2:0]                     res_group_q;
	logic [2:0]                     res_cmd_q;
	logic [63:0]                    res_value_q;
	logic [63:0]                    res_lbits_q;
	logic [6:0]                     res_llen_q;

	logic                           take;
	logic                           bit_in;
	logic                           do_cmd;
	logic [2:0]                     cmd_val;
	logic                           do_fail;
	logic [1:0]                     fail_kind;
	logic                           do_num;
	logic                           do_lbl;
	logic                           do_end;
	logic                           do_clear;
	logic                           emit;
	logic [1:0]                     e_kind;
	logic [2:0]                     e_group;
	logic [2:0]                     e_cmd;
	logic [63:0]                    e_value;
	logic [63:0]                    e_lbits;
	logic [6:0]                     e_llen;
	logic [63:0]                    mag_ext;

	assign take      = head.valid && (!res_valid_q || result_ready);
	assign head_take = take;
	assign bit_in    = (head.sym == wsid_pkg::SYM_T);
	assign mag_ext   = {1'b0, mag_q};

	always_comb begin
		phase_n   = phase_q;
		group_n   = group_q;
		cmd_n     = cmd_q;
		neg_n     = neg_q;
		mag_n     = mag_q;
		lbl_n     = lbl_q;
		lcnt_n    = lcnt_q;
		stopped_n = stopped_q;
		do_cmd    = 1'b0;
		cmd_val   = wsid_pkg::CMD_PUSH;
		do_fail   = 1'b0;
		fail_kind = wsid_pkg::KIND_ILLEGAL;
		do_num    = 1'b0;
		do_lbl    = 1'b0;
		do_end    = 1'b0;
		do_clear  = 1'b0;
		emit      = 1'b0;
		e_kind    = wsid_pkg::KIND_INSTR;
		e_group   = group_q;
		e_cmd     = cmd_q;
		e_value   = '0;
		e_lbits   = '0;
		e_llen    = '0;

		if (take && !stopped_q) begin
			if (head.sym == wsid_pkg::SYM_Z) begin
				if (phase_q == wsid_pkg::PH_GROUP || phase_q == wsid_pkg::PH_GROUP_T) begin
					do_end = 1'b1;
				end else begin
					do_fail = 1'b1;
				end
			end else begin
				unique case (phase_q)
					wsid_pkg::PH_GROUP: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: begin
								group_n = wsid_pkg::GRP_STACK;
								phase_n = wsid_pkg::PH_STACK;
							end
							wsid_pkg::SYM_T: phase_n = wsid_pkg::PH_GROUP_T;
							default: begin
								group_n = wsid_pkg::GRP_FLOW;
								phase_n = wsid_pkg::PH_FLOW;
							end
						endcase
					end
					wsid_pkg::PH_GROUP_T: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: begin
								group_n = wsid_pkg::GRP_ARITH;
								phase_n = wsid_pkg::PH_ARITH;
							end
							wsid_pkg::SYM_T: begin
								group_n = wsid_pkg::GRP_HEAP;
								phase_n = wsid_pkg::PH_HEAP;
							end
							default: begin
								group_n = wsid_pkg::GRP_IO;
								phase_n = wsid_pkg::PH_IO;
							end
						endcase
					end
					wsid_pkg::PH_STACK: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_PUSH;
							end
							wsid_pkg::SYM_T: phase_n = wsid_pkg::PH_STACK_T;
							default:         phase_n = wsid_pkg::PH_STACK_N;
						endcase
					end
					wsid_pkg::PH_STACK_T: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_COPY;
							end
							wsid_pkg::SYM_N: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_SLIDE;
							end
							default: do_fail = 1'b1;
						endcase
					end
					wsid_pkg::PH_STACK_N: begin
						do_cmd = 1'b1;
						unique case (head.sym)
							wsid_pkg::SYM_S: cmd_val = wsid_pkg::CMD_DUP;
							wsid_pkg::SYM_T: cmd_val = wsid_pkg::CMD_SWAP;
							default:         cmd_val = wsid_pkg::CMD_DISCARD;
						endcase
					end
					wsid_pkg::PH_ARITH: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: phase_n = wsid_pkg::PH_ARITH_S;
							wsid_pkg::SYM_T: phase_n = wsid_pkg::PH_ARITH_T;
							default:         do_fail = 1'b1;
						endcase
					end
					wsid_pkg::PH_ARITH_S: begin
						do_cmd = 1'b1;
						unique case (head.sym)
							wsid_pkg::SYM_S: cmd_val = wsid_pkg::CMD_ADD;
							wsid_pkg::SYM_T: cmd_val = wsid_pkg::CMD_SUB;
							default:         cmd_val = wsid_pkg::CMD_MUL;
						endcase
					end
					wsid_pkg::PH_ARITH_T: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_DIV;
							end
							wsid_pkg::SYM_T: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_MOD;
							end
							default: do_fail = 1'b1;
						endcase
					end
					wsid_pkg::PH_HEAP: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_STORE;
							end
							wsid_pkg::SYM_T: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_RETRIEVE;
							end
							default: do_fail = 1'b1;
						endcase
					end
					wsid_pkg::PH_FLOW: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: phase_n = wsid_pkg::PH_FLOW_S;
							wsid_pkg::SYM_T: phase_n = wsid_pkg::PH_FLOW_T;
							default:         phase_n = wsid_pkg::PH_FLOW_N;
						endcase
					end
					wsid_pkg::PH_FLOW_S: begin
						do_cmd = 1'b1;
						unique case (head.sym)
							wsid_pkg::SYM_S: cmd_val = wsid_pkg::CMD_MARK;
							wsid_pkg::SYM_T: cmd_val = wsid_pkg::CMD_CALL;
							default:         cmd_val = wsid_pkg::CMD_JUMP;
						endcase
					end
					wsid_pkg::PH_FLOW_T: begin
						do_cmd = 1'b1;
						unique case (head.sym)
							wsid_pkg::SYM_S: cmd_val = wsid_pkg::CMD_JZ;
							wsid_pkg::SYM_T: cmd_val = wsid_pkg::CMD_JNEG;
							default:         cmd_val = wsid_pkg::CMD_RET;
						endcase
					end
					wsid_pkg::PH_FLOW_N: begin
						if (head.sym == wsid_pkg::SYM_N) begin
							do_cmd  = 1'b1;
							cmd_val = wsid_pkg::CMD_FINISH;
						end else begin
							do_fail = 1'b1;
						end
					end
					wsid_pkg::PH_IO: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: phase_n = wsid_pkg::PH_IO_S;
							wsid_pkg::SYM_T: phase_n = wsid_pkg::PH_IO_T;
							default:         do_fail = 1'b1;
						endcase
					end
					wsid_pkg::PH_IO_S: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_PUTC;
							end
							wsid_pkg::SYM_T: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_PUTN;
							end
							default: do_fail = 1'b1;
						endcase
					end
					wsid_pkg::PH_IO_T: begin
						unique case (head.sym)
							wsid_pkg::SYM_S: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_GETC;
							end
							wsid_pkg::SYM_T: begin
								do_cmd  = 1'b1;
								cmd_val = wsid_pkg::CMD_GETN;
							end
							default: do_fail = 1'b1;
						endcase
					end
					wsid_pkg::PH_SIGN: begin
						if (head.sym == wsid_pkg::SYM_N) begin
							do_fail = 1'b1;
						end else begin
							neg_n   = bit_in;
							phase_n = wsid_pkg::PH_DIGITS;
						end
					end
					wsid_pkg::PH_DIGITS: begin
						if (head.sym == wsid_pkg::SYM_N) begin
							do_num = 1'b1;
						end else begin
							mag_n = {mag_q[wsid_pkg::MAG_W-2:0], bit_in};
						end
					end
					wsid_pkg::PH_LABEL: begin
						if (head.sym == wsid_pkg::SYM_N) begin
							do_lbl = 1'b1;
						end else if (lcnt_q >= LCNT_W'(LABEL_BITS)) begin
							do_fail   = 1'b1;
							fail_kind = wsid_pkg::KIND_OVERFLOW;
						end else begin
							lbl_n  = {lbl_q[LABEL_BITS-2:0], bit_in};
							lcnt_n = lcnt_q + 1'b1;
						end
					end
					default: do_clear = 1'b1;
				endcase
			end

			if (do_cmd) begin
				cmd_n = cmd_val;
				if (group_q == wsid_pkg::GRP_STACK && cmd_val <= wsid_pkg::CMD_SLIDE) begin
					phase_n = wsid_pkg::PH_SIGN;
				end else if (group_q == wsid_pkg::GRP_FLOW && cmd_val <= wsid_pkg::CMD_JNEG) begin
					phase_n = wsid_pkg::PH_LABEL;
				end else begin
					emit     = 1'b1;
					e_cmd    = cmd_val;
					do_clear = 1'b1;
				end
			end

			if (do_num) begin
				emit     = 1'b1;
				e_value  = neg_q ? (64'd0 - mag_ext) : mag_ext;
				do_clear = 1'b1;
			end

			if (do_lbl) begin
				emit     = 1'b1;
				e_lbits  = 64'(lbl_q);
				e_llen   = 7'(lcnt_q);
				do_clear = 1'b1;
			end

			if (do_fail) begin
				emit      = 1'b1;
				e_kind    = fail_kind;
				e_lbits   = 64'(lbl_q);
				e_llen    = 7'(lcnt_q);
				stopped_n = 1'b1;
			end

			if (do_end) begin
				emit      = 1'b1;
				e_kind    = wsid_pkg::KIND_END;
				e_group   = wsid_pkg::GRP_STACK;
				e_cmd     = wsid_pkg::CMD_PUSH;
				do_clear  = 1'b1;
				stopped_n = 1'b1;
			end

			if (do_clear) begin
				phase_n = wsid_pkg::PH_GROUP;
				group_n = '0;
				cmd_n   = '0;
				neg_n   = 1'b0;
				mag_n   = '0;
				lbl_n   = '0;
				lcnt_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= wsid_pkg::PH_GROUP;
			group_q     <= '0;
			cmd_q       <= '0;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			lbl_q       <= '0;
			lcnt_q      <= '0;
			stopped_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			group_q   <= group_n;
			cmd_q     <= cmd_n;
			neg_q     <= neg_n;
			mag_q     <= mag_n;
			lbl_q     <= lbl_n;
			lcnt_q    <= lcnt_n;
			stopped_q <= stopped_n;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_kind_q  <= e_kind;
			res_group_q <= e_group;
			res_cmd_q   <= e_cmd;
			res_value_q <= e_value;
			res_lbits_q <= e_lbits;
			res_llen_q  <= e_llen;
		end
	end

	assign result_valid = res_valid_q;
	assign result_kind  = res_kind_q;
	assign op_group     = res_group_q;
	assign op_command   = res_cmd_q;
	assign push_value   = res_value_q;
	assign label_bits   = res_lbits_q;
	assign label_length = res_llen_q;

endmodule

`default_nettype wire

### rtl/core/whitespace_instruction_decoder.sv
// Decodes program source one byte a beat and gives one result beat for each
// complete instruction, illegal command, label overflow or end of program.
// Source channel: source_valid, source_ready, source_byte. Space, tab, line
// feed and NUL are symbols; every other byte is taken and dropped at once.
// Result channel: result_valid, result_ready and the decoded fields.
// The front classifies bytes into a four-entry symbol queue; the back steps
// the decode state machine by one symbol a cycle into an output register.
// A symbol that completes an instruction passes the symbol queue and then the
// output register before it shows as a result. Throughput is one byte per
// cycle while the receiver does not stall, set by the decode state machine.
// While the receiver stalls, the back holds its result and stops taking
// symbols; the front keeps accepting bytes until its queue is full.
// After an illegal command, a label overflow or the end of program, all
// further bytes are accepted and ignored until reset.
// Reset clears the queue, the output valid flag and the decode state, which
// then awaits the group of the first instruction.
`timescale 1ns / 1ps
`default_nettype none

module whitespace_instruction_decoder #(
	parameter int LABEL_BITS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                source_valid,
	output logic                     source_ready,
	input  wire logic [7:0]          source_byte,
	output logic                     result_valid,
	input  wire logic                result_ready,
	output logic [1:0]               result_kind,
	output logic [2:0]               op_group,
	output logic [2:0]               op_command,
	output logic signed [63:0]       push_value,
	output logic [63:0]              label_bits,
	output logic [6:0]               label_length
);

	wsid_pkg::sym_beat_t head;
	logic                head_take;

	wsid_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.source_valid (source_valid),
		.source_ready (source_ready),
		.source_byte  (source_byte),
		.head         (head),
		.head_take    (head_take)
	);

	wsid_back #(
		.LABEL_BITS (LABEL_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_take    (head_take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.op_group     (op_group),
		.op_command   (op_command),
		.push_value   (push_value),
		.label_bits   (label_bits),
		.label_length (label_length)
	);

endmodule

`default_nettype wire

### dv/tb_whitespace_instruction_decoder.sv
`timescale 1ns / 1ps

module tb_whitespace_instruction_decoder;
	import wsid_pkg::*;

	localparam int LABEL_DEPTH = 64;
	localparam int SOURCE_SYMBOLS = 1850;
	localparam int PHASE_BEATS = 240;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  grp;
		logic [2:0]  cmd;
		logic [63:0] value;
		logic [63:0] lbits;
		logic [6:0]  llen;
	} decoded_t;

	typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic source_valid = 1'b0;
	logic source_ready;
	logic [7:0] source_byte = 8'd0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [1:0] result_kind;
	logic [2:0] op_group;
	logic [2:0] op_command;
	logic signed [63:0] push_value;
	logic [63:0] label_bits;
	logic [6:0] label_length;

	whitespace_instruction_decoder #(.LABEL_BITS(LABEL_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.source_valid(source_valid),
		.source_ready(source_ready),
		.source_byte(source_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_kind(result_kind),
		.op_group(op_group),
		.op_command(op_command),
		.push_value(push_value),
		.label_bits(label_bits),
		.label_length(label_length)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	logic [7:0] source_q[$];
	decoded_t pending_results[$];
	int sym_count = 0;
	int accepted_bytes = 0;
	int results_seen = 0;
	int instr_seen = 0;
	int failures = 0;
	logic hold_rx = 1'b0;
	string ending = "";

	string illegal_seqs [12] = '{"STT", "TSN", "TSTN", "TTN", "NNS", "NNT", "TNN", "TNSN",
		"TNTN", "SSN", "STSN", "STNN"};

	// Decoder state as the block should hold it.
	phase_t      ph = PH_GROUP;
	logic [2:0]  grp = '0;
	logic [2:0]  cmd = '0;
	logic        neg = 1'b0;
	logic [63:0] mag = '0;
	logic [63:0] lab = '0;
	logic [6:0]  lcnt = '0;
	logic        halted = 1'b0;

	task automatic clear_instr();
		ph = PH_GROUP;
		grp = '0;
		cmd = '0;
		neg = 1'b0;
		mag = '0;
		lab = '0;
		lcnt = '0;
	endtask

	task automatic post(input logic [1:0] kind, input logic [63:0] value,
		input logic [63:0] lbits, input logic [6:0] llen);
		decoded_t r;
		r.kind = kind;
		r.grp = grp;
		r.cmd = cmd;
		r.value = value;
		r.lbits = lbits;
		r.llen = llen;
		pending_results.push_back(r);
	endtask

	task automatic fail_with(input logic [1:0] kind);
		post(kind, '0, lab, lcnt);
		halted = 1'b1;
	endtask

	task automatic finish_instr(input logic [63:0] value, input logic [63:0] lbits,
		input logic [6:0] llen);
		post(KIND_INSTR, value, lbits, llen);
		clear_instr();
	endtask

	task automatic take_command(input logic [2:0] c);
		cmd = c;
		if (grp == GRP_STACK && c <= CMD_SLIDE) begin
			ph = PH_SIGN;
		end else if (grp == GRP_FLOW && c <= CMD_JNEG) begin
			ph = PH_LABEL;
		end else begin
			finish_instr('0, '0, '0);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		sym_t s;
		logic [63:0] v;
		if (halted)
			return;
		case (b)
			SP_CODE: s = SYM_S;
			TAB_CODE: s = SYM_T;
			LF_CODE: s = SYM_N;
			NUL_CODE: s = SYM_Z;
			default: return;
		endcase
		if (s == SYM_Z) begin
			if (ph == PH_GROUP || ph == PH_GROUP_T) begin
				clear_instr();
				post(KIND_END, '0, '0, '0);
				halted = 1'b1;
			end else begin
				fail_with(KIND_ILLEGAL);
			end
			return;
		end
		case (ph)
			PH_GROUP: begin
				if (s == SYM_S) begin
					grp = GRP_STACK;
					ph = PH_STACK;
				end else if (s == SYM_T) begin
					ph = PH_GROUP_T;
				end else begin
					grp = GRP_FLOW;
					ph = PH_FLOW;
				end
			end
			PH_GROUP_T: begin
				if (s == SYM_S) begin
					grp = GRP_ARITH;
					ph = PH_ARITH;
				end else if (s == SYM_T) begin
					grp = GRP_HEAP;
					ph = PH_HEAP;
				end else begin
					grp = GRP_IO;
					ph = PH_IO;
				end
			end
			PH_STACK: begin
				if (s == SYM_S)
					take_command(CMD_PUSH);
				else
					ph = (s == SYM_T) ? PH_STACK_T : PH_STACK_N;
			end
			PH_STACK_T: begin
				if (s == SYM_S)
					take_command(CMD_COPY);
				else if (s == SYM_N)
					take_command(CMD_SLIDE);
				else
					fail_with(KIND_ILLEGAL);
			end
			PH_STACK_N: take_command(s == SYM_S ? CMD_DUP : s == SYM_T ? CMD_SWAP : CMD_DISCARD);
			PH_ARITH: begin
				if (s == SYM_N)
					fail_with(KIND_ILLEGAL);
				else
					ph = (s == SYM_S) ? PH_ARITH_S : PH_ARITH_T;
			end
			PH_ARITH_S: take_command(s == SYM_S ? CMD_ADD : s == SYM_T ? CMD_SUB : CMD_MUL);
			PH_ARITH_T: begin
				if (s == SYM_N)
					fail_with(KIND_ILLEGAL);
				else
					take_command(s == SYM_S ? CMD_DIV : CMD_MOD);
			end
			PH_HEAP: begin
				if (s == SYM_N)
					fail_with(KIND_ILLEGAL);
				else
					take_command(s == SYM_S ? CMD_STORE : CMD_RETRIEVE);
			end
			PH_FLOW: ph = (s == SYM_S) ? PH_FLOW_S : (s == SYM_T) ? PH_FLOW_T : PH_FLOW_N;
			PH_FLOW_S: take_command(s == SYM_S ? CMD_MARK : s == SYM_T ? CMD_CALL : CMD_JUMP);
			PH_FLOW_T: take_command(s == SYM_S ? CMD_JZ : s == SYM_T ? CMD_JNEG : CMD_RET);
			PH_FLOW_N: begin
				if (s != SYM_N)
					fail_with(KIND_ILLEGAL);
				else
					take_command(CMD_FINISH);
			end
			PH_IO: begin
				if (s == SYM_N)
					fail_with(KIND_ILLEGAL);
				else
					ph = (s == SYM_S) ? PH_IO_S : PH_IO_T;
			end
			PH_IO_S: begin
				if (s == SYM_N)
					fail_with(KIND_ILLEGAL);
				else
					take_command(s == SYM_S ? CMD_PUTC : CMD_PUTN);
			end
			PH_IO_T: begin
				if (s == SYM_N)
					fail_with(KIND_ILLEGAL);
				else
					take_command(s == SYM_S ? CMD_GETC : CMD_GETN);
			end
			PH_SIGN: begin
				if (s == SYM_N) begin
					fail_with(KIND_ILLEGAL);
				end else begin
					neg = (s == SYM_T);
					ph = PH_DIGITS;
				end
			end
			PH_DIGITS: begin
				if (s == SYM_N) begin
					v = {1'b0, mag[MAG_W-1:0]};
					if (neg)
						v = ~v + 64'd1;
					finish_instr(v, '0, '0);
				end else begin
					mag = {mag[62:0], s == SYM_T};
				end
			end
			PH_LABEL: begin
				if (s == SYM_N) begin
					finish_instr('0, lab, lcnt);
				end else if (lcnt >= LABEL_DEPTH) begin
					fail_with(KIND_OVERFLOW);
				end else begin
					lab = {lab[62:0], s == SYM_T};
					lcnt = lcnt + 7'd1;
				end
			end
			default: clear_instr();
		endcase
	endtask

	// Source program construction.
	function automatic logic [7:0] noise_byte();
		logic [7:0] b;
		do
			b = 8'($urandom);
		while (b == NUL_CODE || b == TAB_CODE || b == LF_CODE || b == SP_CODE);
		return b;
	endfunction

	task automatic put(input sym_t s);
		if ($urandom_range(0, 11) == 0) begin
			source_q.push_back(noise_byte());
			sym_count++;
		end
		case (s)
			SYM_S: source_q.push_back(SP_CODE);
			SYM_T: source_q.push_back(TAB_CODE);
			SYM_N: source_q.push_back(LF_CODE);
			default: source_q.push_back(NUL_CODE);
		endcase
		sym_count++;
	endtask

	task automatic put_str(input string p);
		for (int i = 0; i < p.len(); i++) begin
			case (p[i])
				"S": put(SYM_S);
				"T": put(SYM_T);
				default: put(SYM_N);
			endcase
		end
	endtask

	function automatic string op_code(input logic [2:0] g, input logic [2:0] c);
		case (g)
			GRP_STACK: begin
				case (c)
					CMD_PUSH: return "SS";
					CMD_COPY: return "STS";
					CMD_SLIDE: return "STN";
					CMD_DUP: return "SNS";
					CMD_SWAP: return "SNT";
					default: return "SNN";
				endcase
			end
			GRP_ARITH: begin
				case (c)
					CMD_ADD: return "TSSS";
					CMD_SUB: return "TSST";
					CMD_MUL: return "TSSN";
					CMD_DIV: return "TSTS";
					default: return "TSTT";
				endcase
			end
			GRP_HEAP: return (c == CMD_STORE) ? "TTS" : "TTT";
			GRP_FLOW: begin
				case (c)
					CMD_MARK: return "NSS";
					CMD_CALL: return "NST";
					CMD_JUMP: return "NSN";
					CMD_JZ: return "NTS";
					CMD_JNEG: return "NTT";
					CMD_RET: return "NTN";
					default: return "NNN";
				endcase
			end
			default: begin
				case (c)
					CMD_PUTC: return "TNSS";
					CMD_PUTN: return "TNST";
					CMD_GETC: return "TNTS";
					default: return "TNTT";
				endcase
			end
		endcase
	endfunction

	function automatic int cmd_count(input logic [2:0] g);
		case (g)
			GRP_STACK: return 6;
			GRP_ARITH: return 5;
			GRP_HEAP: return 2;
			GRP_FLOW: return 7;
			default: return 4;
		endcase
	endfunction

	task automatic put_digits(input int n, input fill_t f);
		for (int i = 0; i < n; i++) begin
			case (f)
				FILL_ONES: put(SYM_T);
				FILL_ZEROS: put(SYM_S);
				default: put($urandom_range(0, 1) ? SYM_T : SYM_S);
			endcase
		end
	endtask

	task automatic put_instr(input logic [2:0] g, input logic [2:0] c, input bit negative,
		input int ndig, input fill_t f);
		put_str(op_code(g, c));
		if (g == GRP_STACK && c <= CMD_SLIDE) begin
			put(negative ? SYM_T : SYM_S);
			put_digits(ndig, f);
			put(SYM_N);
		end else if (g == GRP_FLOW && c <= CMD_JNEG) begin
			put_digits(ndig > LABEL_DEPTH ? LABEL_DEPTH : ndig, f);
			put(SYM_N);
		end
	endtask

	task automatic put_random_instr();
		logic [2:0] g;
		logic [2:0] c;
		int r;
		int n;
		fill_t f;
		g = 3'($urandom_range(0, 4));
		c = 3'($urandom_range(0, cmd_count(g) - 1));
		r = $urandom_range(0, 99);
		n = (r < 80) ? $urandom_range(0, 8) : (r < 95) ? $urandom_range(9, 40) :
			$urandom_range(41, 70);
		r = $urandom_range(0, 19);
		f = (r == 0) ? FILL_ONES : (r == 1) ? FILL_ZEROS : FILL_RANDOM;
		put_instr(g, c, 1'($urandom_range(0, 1)), n, f);
	endtask

	// The program can end only once per run, so one way of ending is chosen.
	task automatic put_ending();
		logic [2:0] g;
		logic [2:0] c;
		string p;
		case ($urandom_range(0, 4))
			0: begin
				ending = "end of program";
				put(SYM_Z);
			end
			1: begin
				ending = "end of program after a leading tab";
				put(SYM_T);
				put(SYM_Z);
			end
			2: begin
				ending = "NUL inside an instruction";
				g = 3'($urandom_range(0, 4));
				c = 3'($urandom_range(0, cmd_count(g) - 1));
				p = op_code(g, c);
				if ((g == GRP_STACK && c <= CMD_SLIDE) || (g == GRP_FLOW && c <= CMD_JNEG)) begin
					put_str(p);
					put_digits($urandom_range(0, 5), FILL_RANDOM);
				end else begin
					put_str(p.substr(0, p.len() - 2));
				end
				put(SYM_Z);
			end
			3: begin
				ending = "illegal command";
				put_str(illegal_seqs[$urandom_range(0, 11)]);
			end
			default: begin
				ending = "label overflow";
				put_str(op_code(GRP_FLOW, 3'($urandom_range(0, 4))));
				put_digits(LABEL_DEPTH + 2, FILL_RANDOM);
				put(SYM_N);
			end
		endcase
	endtask

	function automatic int idle_percent(input bit receiver);
		int phase_no;
		phase_no = (accepted_bytes / PHASE_BEATS) % 4;
		if (phase_no == 3)
			return 10;
		if ((phase_no == 1 && !receiver) || (phase_no == 2 && receiver))
			return 81;
		return 0;
	endfunction

	// Source driver and predictor update on each accepted beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (source_valid && source_ready) begin
				decode_byte(source_byte);
				accepted_bytes++;
			end
			if (!source_valid || source_ready) begin
				if (source_q.size() > 0 && $urandom_range(0, 99) >= idle_percent(1'b0)) begin
					source_valid <= 1'b1;
					source_byte <= source_q.pop_front();
				end else begin
					source_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			result_ready <= !hold_rx && $urandom_range(0, 99) >= idle_percent(1'b1);
	end

	// Result monitor.
	always @(posedge clk) begin
		decoded_t got;
		decoded_t want;
		if (arst_n && result_valid && result_ready) begin
			got = {result_kind, op_group, op_command, push_value, label_bits, label_length};
			results_seen++;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("Unexpected result beat: kind %0d group %0d cmd %0d value %0d label %h/%0d",
						got.kind, got.grp, got.cmd, $signed(got.value), got.lbits, got.llen);
			end else begin
				want = pending_results.pop_front();
				if (want.kind == KIND_INSTR)
					instr_seen++;
				if (got.kind !== want.kind || got.grp !== want.grp || got.cmd !== want.cmd ||
					got.value !== want.value || got.lbits !== want.lbits ||
					got.llen !== want.llen) begin
					failures++;
					if (failures <= 10) begin
						$display("Mismatch: expected kind %0d group %0d cmd %0d value %0d label %h/%0d",
							want.kind, want.grp, want.cmd, $signed(want.value), want.lbits,
							want.llen);
						$display("          got      kind %0d group %0d cmd %0d value %0d label %h/%0d",
							got.kind, got.grp, got.cmd, $signed(got.value), got.lbits, got.llen);
					end
				end
			end
		end
	end

	// The receiver holds off for a long stretch so that the symbol queue fills.
	initial begin
		while (accepted_bytes < 120)
			@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#4_000_000;
		$display("Timed out with %0d results still expected.", pending_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		put_instr(GRP_STACK, CMD_PUSH, 1'b0, 63, FILL_ONES);
		put_instr(GRP_STACK, CMD_PUSH, 1'b1, 63, FILL_ONES);
		put_instr(GRP_STACK, CMD_COPY, 1'b1, 64, FILL_ONES);
		put_instr(GRP_STACK, CMD_SLIDE, 1'b1, 0, FILL_RANDOM);
		put_instr(GRP_STACK, CMD_PUSH, 1'b0, 66, FILL_RANDOM);
		put_instr(GRP_STACK, CMD_PUSH, 1'b1, 5, FILL_ZEROS);
		put_instr(GRP_FLOW, CMD_MARK, 1'b0, LABEL_DEPTH, FILL_ONES);
		put_instr(GRP_FLOW, CMD_CALL, 1'b0, 0, FILL_RANDOM);
		put_instr(GRP_FLOW, CMD_JUMP, 1'b0, LABEL_DEPTH, FILL_ZEROS);
		for (int g = 0; g <= 4; g++) begin
			for (int c = 0; c < cmd_count(3'(g)); c++) begin
				if (!((3'(g) == GRP_STACK && 3'(c) <= CMD_SLIDE) ||
					(3'(g) == GRP_FLOW && 3'(c) <= CMD_JUMP)))
					put_instr(3'(g), 3'(c), 1'($urandom_range(0, 1)), 7, FILL_RANDOM);
			end
		end
		while (sym_count < SOURCE_SYMBOLS)
			put_random_instr();
		put_ending();
		// Everything after the ending must be taken and ignored.
		for (int i = 0; i < 20; i++)
			put(sym_t'($urandom_range(0, 3)));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (source_q.size() > 0 || source_valid)
			@(posedge clk);
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (pending_results.size() > 0) begin
			failures += pending_results.size();
			$display("%0d expected results never arrived.", pending_results.size());
		end
		$display("Decoded %0d source beats into %0d results, %0d of them instructions.",
			accepted_bytes, results_seen, instr_seen);
		$display("The program was ended by %s; %0d failures seen.", ending, failures);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
